### design/midi_clock_divider_defines.svh
// ----------------------------------------------------------------------------
// MIDI clock divider assertion macros
// Shared concurrent assertion forms for the checker.
// ----------------------------------------------------------------------------
`ifndef MIDI_CLOCK_DIVIDER_DEFINES_SVH
`define MIDI_CLOCK_DIVIDER_DEFINES_SVH

// Assertion sampled on the rising edge, switched off while reset is high
`define MCD_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Assertion sampled on the rising edge, active during reset as well
`define MCD_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### design/mcd_pkg.sv
// ----------------------------------------------------------------------------
// MIDI clock divider package
// Event codes, widths, divisor limits and shared types.
// ----------------------------------------------------------------------------
`default_nettype none

package mcd_pkg;

  // Field widths
  localparam int OP_W   = 3;
  localparam int POS_W  = 14;
  localparam int DIV_W  = 6;
  localparam int PROD_W = POS_W + 3;            // position * 6 fits in 17 bits
  localparam int STEP_W = $clog2(PROD_W);

  // Divisor limits
  localparam int MAX_DIVIDE   = 48;
  localparam int DIVIDE_RESET = 24;

  // APB register map
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;
  localparam logic [PADDR_W-3:0] REG_CLOCK_DIVIDE = '0;

  // Event codes
  localparam logic [OP_W-1:0] OP_TICK     = 3'd0;
  localparam logic [OP_W-1:0] OP_START    = 3'd1;
  localparam logic [OP_W-1:0] OP_CONTINUE = 3'd2;
  localparam logic [OP_W-1:0] OP_STOP     = 3'd3;
  localparam logic [OP_W-1:0] OP_POSITION = 3'd4;

  // Sequencer states
  typedef enum logic {
    ST_IDLE,
    ST_MOD
  } state_t;

  // Remainder unit control and status
  typedef struct packed {
    logic start;
  } mod_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } mod_sts_t;

endpackage

`default_nettype wire

### design/mcd_if.sv
// ----------------------------------------------------------------------------
// MIDI clock divider channels
// Valid/ready channels for incoming events and outgoing pulse results.
// ----------------------------------------------------------------------------
`default_nettype none

interface mcd_evt_if;
  import mcd_pkg::*;

  logic             valid;
  logic             ready;
  logic [OP_W-1:0]  op;
  logic [POS_W-1:0] song_position;

  modport source (output valid, output op, output song_position, input ready);
  modport sink   (input valid, input op, input song_position, output ready);
endinterface

interface mcd_pulse_if;
  logic valid;
  logic ready;
  logic clock_pulse;
  logic reset_pulse;

  modport source (output valid, output clock_pulse, output reset_pulse, input ready);
  modport sink   (input valid, input clock_pulse, input reset_pulse, output ready);
endinterface

`default_nettype wire

### design/mcd_mod.sv
// ----------------------------------------------------------------------------
// MIDI clock divider remainder unit
// Bit-serial (position * 6) mod divisor, one product bit per cycle, MSB first.
// ----------------------------------------------------------------------------
`default_nettype none

module mcd_mod
  import mcd_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire mod_ctl_t         ctl,
  input  wire logic [POS_W-1:0] song_position,
  input  wire logic [DIV_W-1:0] divisor,
  output      mod_sts_t         sts,
  output      logic [DIV_W-1:0] rem
);

  logic [PROD_W-1:0] shreg;
  logic [STEP_W-1:0] step;
  logic              busy;
  logic              done;
  logic [DIV_W:0]    rem_ext;
  logic [DIV_W:0]    rem_sub;
  logic [PROD_W-1:0] product;

  // Form position * 6 as two shifted copies
  assign product = {1'b0, song_position, 2'b00} + {2'b00, song_position, 1'b0};

  // Shift in the next product bit and conditionally subtract the divisor
  assign rem_ext = {rem, shreg[PROD_W-1]};
  assign rem_sub = rem_ext - {1'b0, divisor};

  // Control: run for one step per product bit
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (ctl.start) begin
        busy <= 1'b1;
        step <= STEP_W'(PROD_W - 1);
      end else if (busy) begin
        step <= step - 1'b1;
        if (step == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath: load the product, then advance one bit a cycle
  always_ff @(posedge clk) begin
    if (ctl.start) begin
      shreg <= product;
      rem   <= '0;
    end else if (busy) begin
      shreg <= {shreg[PROD_W-2:0], 1'b0};
      if (rem_ext >= {1'b0, divisor}) begin
        rem <= rem_sub[DIV_W-1:0];
      end else begin
        rem <= rem_ext[DIV_W-1:0];
      end
    end
  end

  assign sts.busy = busy;
  assign sts.done = done;

endmodule

`default_nettype wire

### design/mcd_cfg.sv
// ----------------------------------------------------------------------------
// MIDI clock divider register block
// APB-style access to the clamped clock divide register.
// ----------------------------------------------------------------------------
`default_nettype none

module mcd_cfg
  import mcd_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [PDATA_W-1:0] pwdata,
  output      logic [PDATA_W-1:0] prdata,
  output      logic               pready,
  output      logic [DIV_W-1:0]   divisor
);

  logic             hit;
  logic             wr_en;
  logic [DIV_W-1:0] wval;
  logic [DIV_W-1:0] divisor_next;

  assign pready = 1'b1;
  assign hit    = (paddr[PADDR_W-1:2] == REG_CLOCK_DIVIDE);
  assign wr_en  = psel && penable && pwrite && pready && hit;
  assign wval   = pwdata[DIV_W-1:0];

  // Clamp the written value into 1..MAX_DIVIDE
  always_comb begin
    if (wval > DIV_W'(MAX_DIVIDE)) begin
      divisor_next = DIV_W'(MAX_DIVIDE);
    end else if (wval == '0) begin
      divisor_next = DIV_W'(1);
    end else begin
      divisor_next = wval;
    end
  end

  // Hold the divisor
  always_ff @(posedge clk) begin
    if (rst) begin
      divisor <= DIV_W'(DIVIDE_RESET);
    end else if (wr_en) begin
      divisor <= divisor_next;
    end
  end

  // Read back
  assign prdata = hit ? {{(PDATA_W-DIV_W){1'b0}}, divisor} : '0;

endmodule

`default_nettype wire

### design/midi_clock_divider.sv
// Path: tick, start, continue, stop and unknown events pass the pending register
// and then the output register; song position first waits for the 17-step
// bit-serial remainder of position * 6 by the divisor.
// Flow: events wait while the pending register is full or a remainder runs; the
// next event is taken while the previous result waits at the output register.
// Reset: transport stopped, count and armed flag cleared, divisor 24, output empty.
// ----------------------------------------------------------------------------
// MIDI clock divider top level
// Divides MIDI timing ticks by a programmable ratio and fires reset pulses.
// ----------------------------------------------------------------------------
`default_nettype none

module midi_clock_divider
  import mcd_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  mcd_evt_if.sink                 evt,
  mcd_pulse_if.source             pulse,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [PDATA_W-1:0] pwdata,
  output      logic [PDATA_W-1:0] prdata,
  output      logic               pready
);

  state_t           state;
  state_t           state_next;
  logic [DIV_W-1:0] divisor;
  logic [DIV_W-1:0] rem;
  mod_ctl_t         mod_ctl;
  mod_sts_t         mod_sts;

  logic             running;
  logic [DIV_W-1:0] tick_count;
  logic             pulse_armed;

  logic             pend_valid;
  logic             pend_clk;
  logic             pend_rst;
  logic             out_valid;
  logic             out_clk;
  logic             out_rst;

  logic             accept;
  logic             move;
  logic [DIV_W-1:0] count_inc;
  logic             fire;

  mcd_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .divisor (divisor)
  );

  mcd_mod u_mod (
    .clk           (clk),
    .rst           (rst),
    .ctl           (mod_ctl),
    .song_position (evt.song_position),
    .divisor       (divisor),
    .sts           (mod_sts),
    .rem           (rem)
  );

  assign accept = evt.valid && evt.ready;

  // Tick decision
  assign count_inc = tick_count + 1'b1;
  assign fire      = running && ((count_inc >= divisor) || pulse_armed);

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept && (evt.op == OP_POSITION)) begin
          state_next = ST_MOD;
        end
      end
      ST_MOD: begin
        if (mod_sts.done) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    evt.ready     = 1'b0;
    mod_ctl.start = 1'b0;
    case (state)
      ST_IDLE: begin
        evt.ready     = !pend_valid;
        mod_ctl.start = evt.valid && !pend_valid && (evt.op == OP_POSITION);
      end
      ST_MOD: begin
        evt.ready = 1'b0;
      end
      default: begin
        evt.ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Transport state update
  always_ff @(posedge clk) begin
    if (rst) begin
      running     <= 1'b0;
      tick_count  <= '0;
      pulse_armed <= 1'b0;
    end else if (accept) begin
      case (evt.op)
        OP_TICK: begin
          if (fire) begin
            tick_count  <= '0;
            pulse_armed <= 1'b0;
          end else if (running) begin
            tick_count <= count_inc;
          end
        end
        OP_START: begin
          running     <= 1'b1;
          tick_count  <= '0;
          pulse_armed <= 1'b1;
        end
        OP_CONTINUE: running <= 1'b1;
        OP_STOP:     running <= 1'b0;
        default: ;
      endcase
    end else if (mod_sts.done) begin
      tick_count <= rem;
      if (rem == '0) begin
        pulse_armed <= 1'b1;
      end
    end
  end

  // Pending result: filled on a finished event, drained into the output register
  assign move = pend_valid && (!out_valid || pulse.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
    end else if (accept && (evt.op != OP_POSITION)) begin
      pend_valid <= 1'b1;
    end else if (mod_sts.done) begin
      pend_valid <= 1'b1;
    end else if (move) begin
      pend_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && (evt.op != OP_POSITION)) begin
      pend_clk <= (evt.op == OP_TICK) && fire;
      pend_rst <= (evt.op == OP_START);
    end else if (mod_sts.done) begin
      pend_clk <= 1'b0;
      pend_rst <= 1'b0;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (move) begin
      out_valid <= 1'b1;
    end else if (pulse.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      out_clk <= pend_clk;
      out_rst <= pend_rst;
    end
  end

  assign pulse.valid       = out_valid;
  assign pulse.clock_pulse = out_clk;
  assign pulse.reset_pulse = out_rst;

endmodule

`default_nettype wire

### design/mcd_checker.sv
// ----------------------------------------------------------------------------
// MIDI clock divider port checker
// Watches the top-level ports and flags illegal result and register behavior.
// ----------------------------------------------------------------------------
`default_nettype none

`include "midi_clock_divider_defines.svh"

module mcd_checker
  import mcd_pkg::*;
(
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire logic               clock_pulse,
  input wire logic               reset_pulse,
  input wire logic               psel,
  input wire logic [PADDR_W-1:0] paddr,
  input wire logic [PDATA_W-1:0] prdata
);

  // A result never carries both a clock pulse and a reset pulse
  `MCD_ASSERT(a_pulse_excl, clk, rst, out_valid |-> !(clock_pulse && reset_pulse), "both pulses set in one result")

  // The divisor read back stays within 1..MAX_DIVIDE
  `MCD_ASSERT(a_div_range, clk, rst, (psel && (paddr[PADDR_W-1:2] == REG_CLOCK_DIVIDE)) |-> ((prdata[DIV_W-1:0] != '0) && (prdata[DIV_W-1:0] <= DIV_W'(MAX_DIVIDE))), "divisor out of range")

  // Reset empties the output
  `MCD_ASSERT_ALWAYS(a_reset_empty, clk, rst |=> !out_valid, "result present after reset")

  // A stalled result holds
  `MCD_ASSERT(a_stall_hold, clk, rst, (out_valid && !out_ready) |=> (out_valid && $stable(clock_pulse) && $stable(reset_pulse)), "stalled result changed")

endmodule

bind midi_clock_divider mcd_checker u_mcd_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (pulse.valid),
  .out_ready   (pulse.ready),
  .clock_pulse (pulse.clock_pulse),
  .reset_pulse (pulse.reset_pulse),
  .psel        (psel),
  .paddr       (paddr),
  .prdata      (prdata)
);

`default_nettype wire
